### rtl/core/cta_pkg.sv
`timescale 1ns / 1ps

package cta_pkg;

    // Field widths of the request and result channels.
    localparam int YEAR_W     = 16;
    localparam int DAY_IN_W   = 12;
    localparam int HOUR_IN_W  = 10;
    localparam int MIN_IN_W   = 12;
    localparam int DAY_W      = 9;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;

    // Width of the shared add/subtract unit and operand widths of the shared multiplier.
    localparam int ACC_W      = 13;
    localparam int MUL_A_W    = YEAR_W;
    localparam int MUL_B_W    = YEAR_W + 1;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    // Gregorian cycle: a year is leap when its residue modulo 400 is a
    // multiple of four other than one of the three century residues.
    localparam int R400_W     = 9;
    localparam int LEAP_CYCLE = 400;
    localparam int CENTURY_1  = LEAP_CYCLE / 4;
    localparam int CENTURY_2  = LEAP_CYCLE / 2;
    localparam int CENTURY_3  = (3 * LEAP_CYCLE) / 4;

    // Default calendar constants.
    localparam int MINUTES_PER_HOUR_DEF = 60;
    localparam int HOURS_PER_DAY_DEF    = 24;
    localparam int DAYS_PER_YEAR_DEF    = 365;

    // Operation codes of a request.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
    } cta_time_t;

    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic             sub;
    } cta_alu_req_t;

    typedef struct packed {
        logic [ACC_W-1:0] res;
        logic             carry;
    } cta_alu_rsp_t;

endpackage

### rtl/core/cta_req_if.sv
`timescale 1ns / 1ps

interface cta_req_if
    import cta_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [YEAR_W-1:0]    year_in;
    logic [DAY_IN_W-1:0]  day_in;
    logic [HOUR_IN_W-1:0] hour_in;
    logic [MIN_IN_W-1:0]  minute_in;

    modport source (
        output valid, operation, year_in, day_in, hour_in, minute_in,
        input  ready
    );

    modport sink (
        input  valid, operation, year_in, day_in, hour_in, minute_in,
        output ready
    );
endinterface

### rtl/core/cta_res_if.sv
`timescale 1ns / 1ps

interface cta_res_if
    import cta_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [YEAR_W-1:0] year_out;
    logic [DAY_W-1:0]  day_out;
    logic [HOUR_W-1:0] hour_out;
    logic [MIN_W-1:0]  minute_out;

    modport source (
        output valid, year_out, day_out, hour_out, minute_out,
        input  ready
    );

    modport sink (
        input  valid, year_out, day_out, hour_out, minute_out,
        output ready
    );
endinterface

### rtl/core/calendar_time_advance_top.sv
`timescale 1ns / 1ps

// Calendar time advance: keeps a clock as year, day of year, hour and minute.
// Each request on the request channel either loads a time (operation 0) or adds
// an interval to the stored time (operation 1); the result is normalized and one
// result is sent on the result channel for every request.
// Both channels use valid/ready; a request is taken when both are high.
// The block takes one request at a time: ready is high only while it is idle.
// A request passes through a minute quotient (reciprocal multiply) and remainder,
// a carry add, the same for the hours, a carry add, the same for the year modulo
// 400, and then the whole years taken off the day count one by one, all on one
// shared multiplier and one shared 13-bit add/subtract unit. The next request
// can be taken once the finished time has gone to the output register.
// The result sits in an output register; while the receiver stalls with that
// register full, the finished time waits in the core and no request is taken.
// Reset clears the stored time to year 0, day 0, 00:00 and empties the output.

module calendar_time_advance_top
    import cta_pkg::*;
#(
    parameter int MINUTES_PER_HOUR = MINUTES_PER_HOUR_DEF,
    parameter int HOURS_PER_DAY    = HOURS_PER_DAY_DEF,
    parameter int DAYS_PER_YEAR    = DAYS_PER_YEAR_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    cta_req_if.sink   request,
    cta_res_if.source result
);

    logic      res_valid;
    logic      res_free;
    cta_time_t res_time;

    // Sequencer with the shared arithmetic unit and the stored time.
    cta_core #(
        .MINUTES_PER_HOUR (MINUTES_PER_HOUR),
        .HOURS_PER_DAY    (HOURS_PER_DAY),
        .DAYS_PER_YEAR    (DAYS_PER_YEAR)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .res_valid (res_valid),
        .res_time  (res_time),
        .res_free  (res_free)
    );

    // Output register in front of the result channel.
    cta_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_time (res_time),
        .free      (res_free),
        .result    (result)
    );

endmodule

### rtl/core/cta_alu.sv
`timescale 1ns / 1ps

module cta_alu
    import cta_pkg::*;
(
    input  cta_alu_req_t req,
    output cta_alu_rsp_t rsp
);

    logic [ACC_W:0] sum;

    // Add, or subtract by adding the complement; on a subtraction the carry
    // out is set when a is not below b.
    assign sum = {1'b0, req.a} + {1'b0, req.b ^ {ACC_W{req.sub}}} + (ACC_W + 1)'(req.sub);

    assign rsp.res   = sum[ACC_W-1:0];
    assign rsp.carry = sum[ACC_W];

endmodule

### rtl/core/cta_core.sv
`timescale 1ns / 1ps

module cta_core
    import cta_pkg::*;
#(
    parameter int MINUTES_PER_HOUR = MINUTES_PER_HOUR_DEF,
    parameter int HOURS_PER_DAY    = HOURS_PER_DAY_DEF,
    parameter int DAYS_PER_YEAR    = DAYS_PER_YEAR_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    cta_req_if.sink   request,
    output logic      res_valid,
    output cta_time_t res_time,
    input  logic      res_free
);

    // Reciprocals are rounded up with as many extra bits as the divisor has, so the
    // quotient is exact for every dividend below 2^13 (2^16 for the year).
    localparam int MIN_SHIFT  = ACC_W + $clog2(MINUTES_PER_HOUR);
    localparam int MIN_RECIP  = ((1 << MIN_SHIFT) + MINUTES_PER_HOUR - 1) / MINUTES_PER_HOUR;
    localparam int HOUR_SHIFT = ACC_W + $clog2(HOURS_PER_DAY);
    localparam int HOUR_RECIP = ((1 << HOUR_SHIFT) + HOURS_PER_DAY - 1) / HOURS_PER_DAY;
    localparam int YMOD_SHIFT = YEAR_W + $clog2(LEAP_CYCLE);
    localparam int YMOD_RECIP = ((1 << YMOD_SHIFT) + LEAP_CYCLE - 1) / LEAP_CYCLE;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIN_Q,
        ST_MIN_R,
        ST_HCARRY,
        ST_HOUR_Q,
        ST_HOUR_R,
        ST_DCARRY,
        ST_YMOD_Q,
        ST_YMOD_R,
        ST_YEAR,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [ACC_W-1:0]    num_reg;
    logic [ACC_W-1:0]    quo_reg;
    logic [YEAR_W-1:0]   yr_reg;
    logic [ACC_W-1:0]    day_reg;
    logic [ACC_W-1:0]    hr_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MIN_W-1:0]    min_reg;
    logic [R400_W-1:0]   r400_reg;
    logic [YEAR_W-1:0]   cur_year_reg;
    logic [DAY_W-1:0]    cur_day_reg;
    logic [HOUR_W-1:0]   cur_hour_reg;
    logic [MIN_W-1:0]    cur_minute_reg;

    logic                accept;
    logic                add_op;
    logic [YEAR_W-1:0]   y_start;
    logic [ACC_W-1:0]    d_start;
    logic [ACC_W-1:0]    h_start;
    logic [ACC_W-1:0]    m_start;
    cta_alu_req_t        alu_req;
    cta_alu_rsp_t        alu_rsp;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_prod;
    logic [ACC_W-1:0]    mul_quo;
    logic                leap;
    logic [ACC_W-1:0]    year_len;
    logic [R400_W-1:0]   r400_inc;

    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;

    // Starting values: either the loaded time or the stored time plus the interval.
    assign add_op  = (request.operation == OP_ADD);
    assign y_start = add_op ? YEAR_W'(cur_year_reg + request.year_in) : request.year_in;
    assign d_start = add_op ? ACC_W'(cur_day_reg) + ACC_W'(request.day_in)
                            : ACC_W'(request.day_in);
    assign h_start = add_op ? ACC_W'(cur_hour_reg) + ACC_W'(request.hour_in)
                            : ACC_W'(request.hour_in);
    assign m_start = add_op ? ACC_W'(cur_minute_reg) + ACC_W'(request.minute_in)
                            : ACC_W'(request.minute_in);

    // Leap year test on the running residue of the year modulo 400.
    assign leap = (r400_reg[1:0] == 2'b00)
               && (r400_reg != R400_W'(CENTURY_1))
               && (r400_reg != R400_W'(CENTURY_2))
               && (r400_reg != R400_W'(CENTURY_3));
    assign year_len = ACC_W'(DAYS_PER_YEAR) + ACC_W'(leap);
    assign r400_inc = (r400_reg == R400_W'(LEAP_CYCLE - 1)) ? '0 : r400_reg + R400_W'(1);

    // Operand selection for the shared multiplier: dividend times reciprocal for a
    // quotient, then quotient times divisor for the remainder.
    always_comb
    begin
        unique case (state_reg)
            ST_MIN_Q:
            begin
                mul_a = MUL_A_W'(num_reg);
                mul_b = MUL_B_W'(MIN_RECIP);
            end
            ST_MIN_R:
            begin
                mul_a = MUL_A_W'(quo_reg);
                mul_b = MUL_B_W'(MINUTES_PER_HOUR);
            end
            ST_HOUR_Q:
            begin
                mul_a = MUL_A_W'(hr_reg);
                mul_b = MUL_B_W'(HOUR_RECIP);
            end
            ST_HOUR_R:
            begin
                mul_a = MUL_A_W'(quo_reg);
                mul_b = MUL_B_W'(HOURS_PER_DAY);
            end
            ST_YMOD_Q:
            begin
                mul_a = yr_reg;
                mul_b = MUL_B_W'(YMOD_RECIP);
            end
            ST_YMOD_R:
            begin
                mul_a = MUL_A_W'(quo_reg);
                mul_b = MUL_B_W'(LEAP_CYCLE);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = {MUL_B_W'(0), mul_a} * {MUL_A_W'(0), mul_b};

    // Quotient taken from the top of the product.
    always_comb
    begin
        unique case (state_reg)
            ST_MIN_Q:  mul_quo = ACC_W'(mul_prod >> MIN_SHIFT);
            ST_HOUR_Q: mul_quo = ACC_W'(mul_prod >> HOUR_SHIFT);
            default:   mul_quo = ACC_W'(mul_prod >> YMOD_SHIFT);
        endcase
    end

    // Operand selection for the shared add/subtract unit. The year remainder is
    // below 400, so it is exact in the low bits alone.
    always_comb
    begin
        unique case (state_reg)
            ST_MIN_R:
            begin
                alu_req.a   = num_reg;
                alu_req.b   = mul_prod[ACC_W-1:0];
                alu_req.sub = 1'b1;
            end
            ST_HCARRY:
            begin
                alu_req.a   = hr_reg;
                alu_req.b   = quo_reg;
                alu_req.sub = 1'b0;
            end
            ST_HOUR_R:
            begin
                alu_req.a   = hr_reg;
                alu_req.b   = mul_prod[ACC_W-1:0];
                alu_req.sub = 1'b1;
            end
            ST_DCARRY:
            begin
                alu_req.a   = day_reg;
                alu_req.b   = quo_reg;
                alu_req.sub = 1'b0;
            end
            ST_YMOD_R:
            begin
                alu_req.a   = yr_reg[ACC_W-1:0];
                alu_req.b   = mul_prod[ACC_W-1:0];
                alu_req.sub = 1'b1;
            end
            ST_YEAR:
            begin
                alu_req.a   = day_reg;
                alu_req.b   = year_len;
                alu_req.sub = 1'b1;
            end
            default:
            begin
                alu_req.a   = '0;
                alu_req.b   = '0;
                alu_req.sub = 1'b1;
            end
        endcase
    end

    cta_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign res_valid       = (state_reg == ST_DONE);
    assign res_time.year   = cur_year_reg;
    assign res_time.day    = cur_day_reg;
    assign res_time.hour   = cur_hour_reg;
    assign res_time.minute = cur_minute_reg;

    // Sequencer and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_reg        <= '0;
            quo_reg        <= '0;
            yr_reg         <= '0;
            day_reg        <= '0;
            hr_reg         <= '0;
            hour_reg       <= '0;
            min_reg        <= '0;
            r400_reg       <= '0;
            cur_year_reg   <= '0;
            cur_day_reg    <= '0;
            cur_hour_reg   <= '0;
            cur_minute_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        yr_reg    <= y_start;
                        day_reg   <= d_start;
                        hr_reg    <= h_start;
                        num_reg   <= m_start;
                        state_reg <= ST_MIN_Q;
                    end
                end
                ST_MIN_Q:
                begin
                    quo_reg   <= mul_quo;
                    state_reg <= ST_MIN_R;
                end
                ST_MIN_R:
                begin
                    min_reg   <= alu_rsp.res[MIN_W-1:0];
                    state_reg <= ST_HCARRY;
                end
                ST_HCARRY:
                begin
                    hr_reg    <= alu_rsp.res;
                    state_reg <= ST_HOUR_Q;
                end
                ST_HOUR_Q:
                begin
                    quo_reg   <= mul_quo;
                    state_reg <= ST_HOUR_R;
                end
                ST_HOUR_R:
                begin
                    hour_reg  <= alu_rsp.res[HOUR_W-1:0];
                    state_reg <= ST_DCARRY;
                end
                ST_DCARRY:
                begin
                    day_reg   <= alu_rsp.res;
                    state_reg <= ST_YMOD_Q;
                end
                ST_YMOD_Q:
                begin
                    quo_reg   <= mul_quo;
                    state_reg <= ST_YMOD_R;
                end
                ST_YMOD_R:
                begin
                    r400_reg  <= alu_rsp.res[R400_W-1:0];
                    state_reg <= ST_YEAR;
                end
                ST_YEAR:
                begin
                    // Take off one whole year while the day count reaches its length.
                    if (alu_rsp.carry)
                    begin
                        day_reg  <= alu_rsp.res;
                        yr_reg   <= yr_reg + YEAR_W'(1);
                        r400_reg <= (yr_reg == {YEAR_W{1'b1}}) ? '0 : r400_inc;
                    end
                    else
                    begin
                        cur_year_reg   <= yr_reg;
                        cur_day_reg    <= day_reg[DAY_W-1:0];
                        cur_hour_reg   <= hour_reg;
                        cur_minute_reg <= min_reg;
                        state_reg      <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (res_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // An accepted request always starts with the minute quotient.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MIN_Q))
        else $error("accepted request did not start the minute quotient");

    // Every remainder lies below its divisor.
    a_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIN_R || state_reg == ST_HOUR_R || state_reg == ST_YMOD_R)
        |-> (MUL_B_W'(alu_rsp.res) < mul_b))
        else $error("division remainder out of range");

    // The year residue stays within one Gregorian cycle.
    a_r400_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YEAR) |-> (r400_reg < R400_W'(LEAP_CYCLE)))
        else $error("year residue out of range");

    // A finished time is normalized in its minute, hour and day fields.
    a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE)
        |-> (ACC_W'(cur_minute_reg) < ACC_W'(MINUTES_PER_HOUR))
         && (ACC_W'(cur_hour_reg) < ACC_W'(HOURS_PER_DAY))
         && (ACC_W'(cur_day_reg) < ACC_W'(DAYS_PER_YEAR + 1)))
        else $error("result time not normalized");

endmodule

### rtl/core/cta_out_reg.sv
`timescale 1ns / 1ps

module cta_out_reg
    import cta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cta_time_t push_time,
    output logic      free,
    cta_res_if.source result
);

    logic      valid_reg;
    cta_time_t data_reg;

    // The register can take a new result when it is empty or being drained.
    assign free = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            data_reg  <= '0;
        end
        else if (push && free)
        begin
            valid_reg <= 1'b1;
            data_reg  <= push_time;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign result.valid      = valid_reg;
    assign result.year_out   = data_reg.year;
    assign result.day_out    = data_reg.day;
    assign result.hour_out   = data_reg.hour;
    assign result.minute_out = data_reg.minute;

endmodule
